// File: sv/wola_pkg.sv
// ----------------------------------------------------------------------------
// wola_pkg
// Shared types, constants and the Hann coefficient function of the framer.
// ----------------------------------------------------------------------------
package wola_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int WG_W     = 32;
  localparam int STORE_W  = 24;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  localparam logic signed [STORE_W-1:0] STORE_MAX = 24'sh7FFFFF;
  localparam logic signed [STORE_W-1:0] STORE_MIN = 24'sh800000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } wola_in_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } wola_out_t;

  // sin^2 of a Q30 angle, Taylor series to x^11, result Q0.16 clamped
  function automatic logic [15:0] hann_from_angle(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] h;
    logic [63:0] w;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - (((x2 * Q30_ONE) >> 30) / 110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 6);
    s  = (x * t) >> 30;
    h  = (s * s) >> 30;
    w  = (h + 64'd8192) >> 14;
    return (w > 64'd65535) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

// File: sv/wola_hist.sv
// ----------------------------------------------------------------------------
// wola_hist
// History ring of dry samples, one region per channel, with write pointer
// and fill tracking so never-written entries read as zero.
// ----------------------------------------------------------------------------
module wola_hist #(
  parameter int FRAME_LEN  = 512,
  parameter int RING_DEPTH = 8192,
  parameter int CHANNELS   = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic                          wr_ch_i,
  input  wola_pkg::sample_t             wr_data_i,
  input  logic                          adv_i,
  input  logic                          rd_en_i,
  input  logic                          rd_ch_i,
  input  logic [$clog2(RING_DEPTH)-1:0] rd_pos_i,
  output wola_pkg::sample_t             rd_data_o,
  output logic [$clog2(RING_DEPTH)-1:0] start_pos_o
);
  import wola_pkg::*;

  localparam int RAW  = $clog2(RING_DEPTH);
  localparam int HAW  = $clog2(CHANNELS * RING_DEPTH);
  localparam int BACK = FRAME_LEN % RING_DEPTH;

  sample_t            ring_mem [CHANNELS*RING_DEPTH];
  sample_t            rd_q;
  logic               rd_ok_q;
  logic [RAW-1:0]     wi_q;
  logic               wrap_q;
  logic [HAW-1:0]     wr_addr;
  logic [HAW-1:0]     rd_addr;

  assign wr_addr = wr_ch_i ? HAW'(RING_DEPTH) + HAW'(wi_q) : HAW'(wi_q);
  assign rd_addr = rd_ch_i ? HAW'(RING_DEPTH) + HAW'(rd_pos_i) : HAW'(rd_pos_i);

  assign start_pos_o = (wi_q >= RAW'(BACK)) ? wi_q - RAW'(BACK)
                                            : wi_q + RAW'(RING_DEPTH - BACK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q   <= '0;
      wrap_q <= 1'b0;
    end else if (adv_i) begin
      if (wi_q == RAW'(RING_DEPTH - 1)) begin
        wi_q   <= '0;
        wrap_q <= 1'b1;
      end else begin
        wi_q <= wi_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ring_mem[wr_addr] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q    <= ring_mem[rd_addr];
      rd_ok_q <= wrap_q || (rd_pos_i < wi_q);
    end
  end

  assign rd_data_o = rd_ok_q ? rd_q : '0;

endmodule

// File: sv/wola_frame.sv
// ----------------------------------------------------------------------------
// wola_frame
// Overlap-add store, Hann window ROM and the read-modify-write pipeline
// that adds one windowed frame per hop, zeroing the first HOP_LEN taps.
// ----------------------------------------------------------------------------
module wola_frame #(
  parameter int FRAME_LEN  = 512,
  parameter int HOP_LEN    = 64,
  parameter int RING_DEPTH = 8192,
  parameter int CHANNELS   = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [wola_pkg::GAIN_W-1:0]   gain_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          head_rd_i,
  input  logic                          head_ch_i,
  input  logic [$clog2(HOP_LEN+1)-1:0]  hop_i,
  output wola_pkg::sample_t             head_o,
  output logic                          hist_rd_o,
  output logic                          hist_ch_o,
  output logic [$clog2(RING_DEPTH)-1:0] hist_pos_o,
  input  logic [$clog2(RING_DEPTH)-1:0] start_pos_i,
  input  wola_pkg::sample_t             hist_data_i
);
  import wola_pkg::*;

  localparam int JW       = $clog2(FRAME_LEN);
  localparam int RAW      = $clog2(RING_DEPTH);
  localparam int HC_W     = $clog2(HOP_LEN + 1);
  localparam int OAW      = $clog2(CHANNELS * FRAME_LEN);
  localparam int SW       = ((JW > HC_W) ? JW : HC_W) + 1;
  localparam bit CLR_ALL  = (HOP_LEN >= FRAME_LEN);
  localparam int HOP_CMP  = CLR_ALL ? 0 : HOP_LEN;
  localparam int HOP_MOD  = HOP_LEN % FRAME_LEN;

  // window ROM
  logic [15:0] win_tab [FRAME_LEN];
  for (genvar n = 0; n < FRAME_LEN; n++) begin : g_win
    localparam logic [63:0] K = (n <= FRAME_LEN / 2) ? 64'(n) : 64'(FRAME_LEN - n);
    localparam logic [63:0] X = (K * PI_Q30 + 64'(FRAME_LEN / 2)) / 64'(FRAME_LEN);
    localparam logic [15:0] W = hann_from_angle(X);
    assign win_tab[n] = W;
  end

  logic signed [STORE_W-1:0] ola_mem [CHANNELS*FRAME_LEN];

  logic               run_q;
  logic               ch_q;
  logic [JW-1:0]      j_q;
  logic [RAW-1:0]     pos_q;
  logic [JW-1:0]      phys_q;
  logic [JW-1:0]      base_q;
  logic [JW-1:0]      base_d;
  logic               epoch_q;
  logic               v1_q, v2_q, v3_q;
  logic               done;

  logic [OAW-1:0]     fr_addr;
  logic [OAW-1:0]     head_addr;
  logic [OAW-1:0]     ola_ra;
  logic               ola_re;
  logic               clr_now;
  logic [SW-1:0]      hsum;
  logic [JW-1:0]      hphys;
  logic               h_in_range;
  logic [JW:0]        bsum;

  logic signed [STORE_W-1:0] ola_rd_q;
  logic                      hmask_q;
  logic [15:0]               win_q;
  logic                      clr1_q, clr2_q, clr3_q;
  logic [OAW-1:0]            wa1_q, wa2_q, wa3_q;
  logic [WG_W-1:0]           wg_q;
  sample_t                   samp_q;
  logic signed [STORE_W-1:0] acc2_q, acc3_q;
  logic signed [48:0]        prod_q;
  logic signed [48:0]        rnd;
  sample_t                   wv;
  logic signed [STORE_W:0]   sum;
  logic signed [STORE_W-1:0] wr_data;
  logic signed [STORE_W-1:0] hv;

  // issue side
  assign fr_addr   = ch_q ? OAW'(FRAME_LEN) + OAW'(phys_q) : OAW'(phys_q);
  assign clr_now   = CLR_ALL || (j_q < JW'(HOP_CMP));

  assign hsum       = SW'(base_q) + SW'(hop_i);
  assign h_in_range = SW'(hop_i) < SW'(FRAME_LEN);
  assign hphys      = (hsum >= SW'(FRAME_LEN)) ? JW'(hsum - SW'(FRAME_LEN)) : JW'(hsum);
  assign head_addr  = head_ch_i ? OAW'(FRAME_LEN) + OAW'(hphys) : OAW'(hphys);

  assign ola_ra = run_q ? fr_addr : head_addr;
  assign ola_re = run_q || head_rd_i;

  assign hist_rd_o  = run_q;
  assign hist_ch_o  = ch_q;
  assign hist_pos_o = pos_q;

  assign busy_o = run_q || v1_q || v2_q || v3_q;
  assign done   = v3_q && !v2_q && !v1_q && !run_q;

  assign bsum   = (JW+1)'(base_q) + (JW+1)'(HOP_MOD);
  assign base_d = (bsum >= (JW+1)'(FRAME_LEN)) ? JW'(bsum - (JW+1)'(FRAME_LEN)) : JW'(bsum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      ch_q    <= 1'b0;
      j_q     <= '0;
      pos_q   <= '0;
      phys_q  <= '0;
      base_q  <= '0;
      epoch_q <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
    end else begin
      v1_q <= run_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (done) begin
        base_q  <= base_d;
        epoch_q <= 1'b1;
      end
      if (start_i) begin
        run_q  <= 1'b1;
        ch_q   <= 1'b0;
        j_q    <= '0;
        pos_q  <= start_pos_i;
        phys_q <= base_q;
      end else if (run_q) begin
        if (j_q == JW'(FRAME_LEN - 1)) begin
          j_q    <= '0;
          pos_q  <= start_pos_i;
          phys_q <= base_q;
          if (ch_q == 1'(CHANNELS - 1)) begin
            run_q <= 1'b0;
          end else begin
            ch_q <= 1'b1;
          end
        end else begin
          j_q    <= j_q + 1'b1;
          pos_q  <= (pos_q == RAW'(RING_DEPTH - 1)) ? '0 : pos_q + 1'b1;
          phys_q <= (phys_q == JW'(FRAME_LEN - 1)) ? '0 : phys_q + 1'b1;
        end
      end
    end
  end

  // weighting pipeline
  assign rnd     = prod_q + 49'sd2147483648;
  assign wv      = rnd[47:32];
  assign sum     = {acc3_q[STORE_W-1], acc3_q} + {{(STORE_W-SAMPLE_W+1){wv[SAMPLE_W-1]}}, wv};
  assign wr_data = clr3_q ? '0
                 : (sum[STORE_W] != sum[STORE_W-1]) ? (sum[STORE_W] ? STORE_MIN : STORE_MAX)
                 : sum[STORE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ola_re) begin
      ola_rd_q <= ola_mem[ola_ra];
    end
    if (head_rd_i) begin
      hmask_q <= h_in_range;
    end
    if (run_q) begin
      win_q <= win_tab[j_q];
    end
    if (v3_q) begin
      ola_mem[wa3_q] <= wr_data;
    end
    clr1_q <= clr_now;
    wa1_q  <= fr_addr;
    clr2_q <= clr1_q;
    wa2_q  <= wa1_q;
    wg_q   <= WG_W'(win_q) * WG_W'(gain_i);
    samp_q <= hist_data_i;
    acc2_q <= epoch_q ? ola_rd_q : '0;
    clr3_q <= clr2_q;
    wa3_q  <= wa2_q;
    acc3_q <= acc2_q;
    prod_q <= samp_q * $signed({1'b0, wg_q});
  end

  // head read, clamped to Q1.15
  assign hv = (epoch_q && hmask_q) ? ola_rd_q : '0;

  always_comb begin
    if (hv > 24'sd32767) begin
      head_o = 16'sh7FFF;
    end else if (hv < -24'sd32768) begin
      head_o = 16'sh8000;
    end else begin
      head_o = hv[SAMPLE_W-1:0];
    end
  end

endmodule

// File: sv/windowed_overlap_add_framer.sv
// ----------------------------------------------------------------------------
// windowed_overlap_add_framer
// Flow: an accepted item steps through S_ITEM, S_CAP and S_OUT, and its
// result is registered out; input stalls until the item is done. Every
// HOP_LEN-th item then adds a frame pass, one window tap per cycle through
// the single read port of the overlap store, which also holds off input.
// Reset: gain to 0.25, pointers cleared; stores are not swept, unwritten
// history and the store before its first frame read as zero.
// ----------------------------------------------------------------------------
module windowed_overlap_add_framer #(
  parameter int FRAME_LEN  = 512,
  parameter int HOP_LEN    = 64,
  parameter int RING_DEPTH = 8192,
  parameter int CHANNELS   = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  wola_pkg::wola_in_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output wola_pkg::wola_out_t         out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [wola_pkg::GAIN_W-1:0] cfg_data_i
);
  import wola_pkg::*;

  localparam int HC_W = $clog2(HOP_LEN + 1);
  localparam int RAW  = $clog2(RING_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ITEM   = 3'd1;
  localparam logic [2:0] S_CAP    = 3'd2;
  localparam logic [2:0] S_OUT    = 3'd3;
  localparam logic [2:0] S_FSTART = 3'd4;
  localparam logic [2:0] S_FWAIT  = 3'd5;

  logic [2:0]        state_q;
  logic [2:0]        state_d;
  logic              ch_q;
  logic [HC_W-1:0]   hop_q;
  logic [HC_W-1:0]   hop_d;
  logic [GAIN_W-1:0] gain_q;
  logic              out_valid_q;
  wola_out_t         out_q;
  wola_in_t          in_q;
  sample_t           head_q [2];
  logic              cap_v_q;
  logic              cap_ch_q;

  logic              in_acc;
  logic              out_free;
  logic              out_load;
  logic              item_rd;
  logic              frame_busy;
  sample_t           head;
  sample_t           wr_sample;
  logic              hist_rd;
  logic              hist_ch;
  logic [RAW-1:0]    hist_pos;
  logic [RAW-1:0]    start_pos;
  sample_t           hist_data;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == S_OUT) && out_free;
  assign item_rd     = (state_q == S_ITEM);
  assign wr_sample   = ch_q ? in_q.right_in : in_q.left_in;
  assign hop_d       = hop_q + 1'b1;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_ITEM;
      S_ITEM:   if (ch_q == 1'(CHANNELS - 1)) state_d = S_CAP;
      S_CAP:    state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = (hop_d == HC_W'(HOP_LEN)) ? S_FSTART : S_IDLE;
        end
      end
      S_FSTART: state_d = S_FWAIT;
      S_FWAIT:  if (!frame_busy) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= 1'b0;
      hop_q       <= '0;
      gain_q      <= GAIN_RESET;
      out_valid_q <= 1'b0;
      cap_v_q     <= 1'b0;
      cap_ch_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cap_v_q <= item_rd;
      cap_ch_q <= ch_q;
      if (cfg_valid_i && cfg_ready_o) begin
        gain_q <= cfg_data_i;
      end
      if (in_acc) begin
        ch_q <= 1'b0;
      end else if (item_rd) begin
        ch_q <= ch_q + 1'b1;
      end
      if (out_load) begin
        hop_q <= (hop_d == HC_W'(HOP_LEN)) ? '0 : hop_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (cap_v_q) begin
      head_q[cap_ch_q] <= head;
    end
    if (out_load) begin
      out_q.left_out  <= head_q[0];
      out_q.right_out <= (CHANNELS > 1) ? head_q[1] : '0;
    end
  end

  wola_hist #(
    .FRAME_LEN  (FRAME_LEN),
    .RING_DEPTH (RING_DEPTH),
    .CHANNELS   (CHANNELS)
  ) u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (item_rd),
    .wr_ch_i     (ch_q),
    .wr_data_i   (wr_sample),
    .adv_i       (out_load),
    .rd_en_i     (hist_rd),
    .rd_ch_i     (hist_ch),
    .rd_pos_i    (hist_pos),
    .rd_data_o   (hist_data),
    .start_pos_o (start_pos)
  );

  wola_frame #(
    .FRAME_LEN  (FRAME_LEN),
    .HOP_LEN    (HOP_LEN),
    .RING_DEPTH (RING_DEPTH),
    .CHANNELS   (CHANNELS)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_i      (gain_q),
    .start_i     (state_q == S_FSTART),
    .busy_o      (frame_busy),
    .head_rd_i   (item_rd),
    .head_ch_i   (ch_q),
    .hop_i       (hop_q),
    .head_o      (head),
    .hist_rd_o   (hist_rd),
    .hist_ch_o   (hist_ch),
    .hist_pos_o  (hist_pos),
    .start_pos_i (start_pos),
    .hist_data_i (hist_data)
  );

endmodule
